/* rtl/mbq_pkg.sv */
package mbq_pkg;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B1    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B2    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd5;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned COEF_W     = 32;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned CHANNEL_W  = 9;
	localparam int unsigned FS_W       = 16;
	localparam int unsigned LIM_W      = 17;
	localparam int unsigned HIST_W     = 48;
	localparam int unsigned FRAC_BITS  = 28;

	localparam logic signed [COEF_W-1:0] COEF_A0_RST = 32'sh1000_0000;
	localparam logic [FS_W-1:0] FULL_SCALE_RST = 16'd32768;

	// Coefficients and the effective saturation bound as seen by the datapath.
	typedef struct packed {
		logic signed [COEF_W-1:0] a0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic        [LIM_W-1:0]  lim;
	} coef_t;

	// Saturate a wide signed sum to the 48-bit history range.
	function automatic logic signed [HIST_W-1:0] sat48(input logic signed [53:0] v);
		logic [6:0] top;
		top = v[53:47];
		if (top == 7'h00 || top == 7'h7F) begin
			return v[HIST_W-1:0];
		end
		return v[53] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
	endfunction

endpackage

/* rtl/mbq_in_if.sv */
interface mbq_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mbq_pkg::SAMPLE_W-1:0]  sample;
	logic        [mbq_pkg::CHANNEL_W-1:0] channel;
	logic                                 restart;

	modport source (output valid, output sample, output channel, output restart, input ready);
	modport sink   (input valid, input sample, input channel, input restart, output ready);
endinterface

/* rtl/mbq_out_if.sv */
interface mbq_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mbq_pkg::SAMPLE_W-1:0]  filtered;
	logic        [mbq_pkg::CHANNEL_W-1:0] out_channel;

	modport source (output valid, output filtered, output out_channel, input ready);
	modport sink   (input valid, input filtered, input out_channel, output ready);
endinterface

/* rtl/multichannel_biquad_filter_top.sv */
// Channel  Direction  Handshake         Payload
// din      in         din.valid/ready   sample[15:0] signed, channel[8:0], restart
// dout     out        dout.valid/ready  filtered[15:0] signed, out_channel[8:0]
// config   in         wr_en             wr_index[2:0], wr_data[31:0]
//
// Each word goes through accumulate after the history read, partial
// products of the feedback terms, recombination, then writeback; the next
// word is taken in the writeback cycle, with forwarding for the same channel.
// After reset the history memory is swept to zero, one entry a cycle, over
// all NUM_CHANNELS entries, during which din.ready stays low.
// A full output register stalls the writeback until dout is taken.
module multichannel_biquad_filter_top #(
	parameter int unsigned NUM_CHANNELS = 512
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [mbq_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [mbq_pkg::CFG_DATA_W-1:0]   wr_data,
	mbq_in_if.sink                           din,
	mbq_out_if.source                        dout
);

	mbq_pkg::coef_t coef;

	mbq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.coef     (coef)
	);

	mbq_core #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef),
		.din    (din),
		.dout   (dout)
	);

endmodule

/* rtl/mbq_ram.sv */
module mbq_ram #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = 512
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/mbq_cfg.sv */
module mbq_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [mbq_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [mbq_pkg::CFG_DATA_W-1:0]       wr_data,
	output mbq_pkg::coef_t                       coef
);

	logic signed [mbq_pkg::COEF_W-1:0] a0_q, a1_q, a2_q, b1_q, b2_q;
	logic        [mbq_pkg::FS_W-1:0]   full_scale_q;

	// Register file; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a0_q         <= mbq_pkg::COEF_A0_RST;
			a1_q         <= '0;
			a2_q         <= '0;
			b1_q         <= '0;
			b2_q         <= '0;
			full_scale_q <= mbq_pkg::FULL_SCALE_RST;
		end else if (wr_en) begin
			case (wr_index)
				mbq_pkg::REG_COEF_A0:    a0_q <= $signed(wr_data);
				mbq_pkg::REG_COEF_A1:    a1_q <= $signed(wr_data);
				mbq_pkg::REG_COEF_A2:    a2_q <= $signed(wr_data);
				mbq_pkg::REG_COEF_B1:    b1_q <= $signed(wr_data);
				mbq_pkg::REG_COEF_B2:    b2_q <= $signed(wr_data);
				mbq_pkg::REG_FULL_SCALE: full_scale_q <= wr_data[mbq_pkg::FS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A bound of zero acts as one, and anything above 32768 acts as 32768.
	always_comb begin
		coef.a0 = a0_q;
		coef.a1 = a1_q;
		coef.a2 = a2_q;
		coef.b1 = b1_q;
		coef.b2 = b2_q;
		if (full_scale_q == '0) begin
			coef.lim = 17'd1;
		end else if (full_scale_q > 16'd32768) begin
			coef.lim = 17'd32768;
		end else begin
			coef.lim = {1'b0, full_scale_q};
		end
	end

endmodule

/* rtl/mbq_core.sv */
module mbq_core #(
	parameter int unsigned NUM_CHANNELS = 512
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mbq_pkg::coef_t coef,
	mbq_in_if.sink         din,
	mbq_out_if.source      dout
);

	localparam int unsigned ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int unsigned MEM_W  = 2 * mbq_pkg::HIST_W;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_CHANNELS - 1);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_ACC   = 6'b000100,
		ST_BMUL  = 6'b001000,
		ST_COMB  = 6'b010000,
		ST_WB    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_cnt_q;

	// Stage registers.
	logic signed [47:0] p0_s1, p1_s1, p2_s1;
	logic [mbq_pkg::CHANNEL_W-1:0] ch_s1;
	logic ch_ok_s1, restart_s1, fwd_s1;
	logic [MEM_W-1:0] fwd_q;
	logic signed [47:0] acc_s2, z2_s2;
	logic signed [55:0] pp1_hi_s3, pp2_hi_s3;
	logic signed [56:0] pp1_lo_s3, pp2_lo_s3;
	logic signed [51:0] m1_s4, m2_s4;

	logic out_valid_q;
	logic signed [mbq_pkg::SAMPLE_W-1:0] filt_q;
	logic [mbq_pkg::CHANNEL_W-1:0] och_q;

	logic in_acc, out_free, wb_done, din_ready;
	logic ch_ok_in;
	logic [ADDR_W-1:0] in_addr, wb_addr;
	logic signed [47:0] mul_p0, mul_p1, mul_p2;
	logic [MEM_W-1:0] ram_rdata, ram_wdata, hist_cur;
	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic signed [47:0] z1_sel, z2_sel;
	logic signed [23:0] acc_hi;
	logic signed [24:0] acc_lo;
	logic signed [79:0] prod1, prod2;
	logic signed [47:0] h1_new, h2_new;
	logic [48:0] trunc_sum;
	logic signed [20:0] t_val, lim_pos, hi_b, lo_b;
	logic signed [mbq_pkg::SAMPLE_W-1:0] filt_new;

	// Handshake decode.
	assign out_free  = !out_valid_q || dout.ready;
	assign wb_done   = (state_q == ST_WB) && out_free;
	assign din_ready = (state_q == ST_IDLE) || wb_done;
	assign din.ready = din_ready;
	assign in_acc    = din.valid && din_ready;
	assign ch_ok_in  = 32'(din.channel) < NUM_CHANNELS;
	assign in_addr   = ADDR_W'(din.channel);
	assign wb_addr   = ADDR_W'(ch_s1);

	// Feedforward products are formed straight off the input word.
	assign mul_p0 = coef.a0 * din.sample;
	assign mul_p1 = coef.a1 * din.sample;
	assign mul_p2 = coef.a2 * din.sample;

	// History memory: z1 in the upper half, z2 in the lower half.
	assign ram_we    = (state_q == ST_CLEAR) || (wb_done && ch_ok_s1);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : wb_addr;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : {h1_new, h2_new};

	mbq_ram #(
		.WIDTH (MEM_W),
		.DEPTH (NUM_CHANNELS)
	) u_hist_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	// History used by this word: forwarded, read, or zero on restart or for an out-of-range channel.
	always_comb begin
		hist_cur = fwd_s1 ? fwd_q : ram_rdata;
		if (restart_s1 || !ch_ok_s1) begin
			z1_sel = '0;
			z2_sel = '0;
		end else begin
			z1_sel = $signed(hist_cur[MEM_W-1:mbq_pkg::HIST_W]);
			z2_sel = $signed(hist_cur[mbq_pkg::HIST_W-1:0]);
		end
	end

	// Split the accumulator into a signed high and unsigned low half.
	assign acc_hi = $signed(acc_s2[47:24]);
	assign acc_lo = $signed({1'b0, acc_s2[23:0]});

	// Recombine the partial products; the shift floors toward minus infinity.
	assign prod1 = $signed({pp1_hi_s3, 24'd0}) + 80'(pp1_lo_s3);
	assign prod2 = $signed({pp2_hi_s3, 24'd0}) + 80'(pp2_lo_s3);

	// New history words.
	assign h1_new = mbq_pkg::sat48(54'(p1_s1) + 54'(z2_s2) - 54'(m1_s4));
	assign h2_new = mbq_pkg::sat48(54'(p2_s1) - 54'(m2_s4));

	// Output: truncate toward zero, then clamp to the bounds.
	always_comb begin
		trunc_sum = 49'(acc_s2) + (acc_s2[47] ? 49'(28'hFFF_FFFF) : 49'd0);
		t_val     = $signed(trunc_sum[48:28]);
		lim_pos   = $signed({4'd0, coef.lim});
		hi_b      = lim_pos - 21'sd1;
		lo_b      = -lim_pos;
		if (t_val > hi_b) begin
			filt_new = hi_b[mbq_pkg::SAMPLE_W-1:0];
		end else if (t_val < lo_b) begin
			filt_new = lo_b[mbq_pkg::SAMPLE_W-1:0];
		end else begin
			filt_new = t_val[mbq_pkg::SAMPLE_W-1:0];
		end
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC:  state_d = ST_BMUL;
			ST_BMUL: state_d = ST_COMB;
			ST_COMB: state_d = ST_WB;
			ST_WB: begin
				if (wb_done) begin
					state_d = in_acc ? ST_ACC : ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			fwd_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (wb_done) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				fwd_s1 <= wb_done && ch_ok_s1 && (din.channel == ch_s1);
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			p0_s1      <= mul_p0;
			p1_s1      <= mul_p1;
			p2_s1      <= mul_p2;
			ch_s1      <= din.channel;
			ch_ok_s1   <= ch_ok_in;
			restart_s1 <= din.restart;
		end
		if (state_q == ST_ACC) begin
			acc_s2 <= mbq_pkg::sat48(54'(p0_s1) + 54'(z1_sel));
			z2_s2  <= z2_sel;
		end
		if (state_q == ST_BMUL) begin
			pp1_hi_s3 <= coef.b1 * acc_hi;
			pp1_lo_s3 <= coef.b1 * acc_lo;
			pp2_hi_s3 <= coef.b2 * acc_hi;
			pp2_lo_s3 <= coef.b2 * acc_lo;
		end
		if (state_q == ST_COMB) begin
			m1_s4 <= $signed(prod1[79:28]);
			m2_s4 <= $signed(prod2[79:28]);
		end
		if (wb_done) begin
			fwd_q  <= {h1_new, h2_new};
			filt_q <= filt_new;
			och_q  <= ch_s1;
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.filtered    = filt_q;
	assign dout.out_channel = och_q;

	// No word is taken while the history memory is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !din_ready)
		else $error("word accepted during history clear");

	// An accepted word always starts the accumulate step next.
	a_accept_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_ACC))
		else $error("accepted word did not enter accumulate");

	// A new result appears only right after a writeback.
	a_result_after_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WB))
		else $error("result appeared without writeback");

	// Forwarding is only in effect for a word taken during a writeback.
	a_fwd_source: assert property (@(posedge clk) disable iff (!arst_n)
		(fwd_s1 && state_q == ST_ACC) |-> $past(state_q == ST_WB))
		else $error("forwarded history without a preceding writeback");

	// Outside the clear sweep the memory is written only on writeback.
	a_write_in_wb: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || wb_done))
		else $error("history written outside writeback");

endmodule
